// File: src/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types, constants and constant tables for the gamma correction block.
// ----------------------------------------------------------------------------
package rgc_pkg;

  localparam int SAMPLE_BITS   = 8;
  localparam int CHANNEL_COUNT = 3;
  localparam int MAXV          = (1 << SAMPLE_BITS) - 1;
  localparam int FRAC_BITS     = 30;
  localparam int GAMMA_W       = 16;
  localparam int GAMMA_FRAC    = 12;
  localparam int N_MAX         = 20;
  localparam int N_W           = $clog2(N_MAX + 1);
  localparam int L_W           = FRAC_BITS + $clog2(SAMPLE_BITS + 1);
  localparam int Y_W           = L_W + GAMMA_W - GAMMA_FRAC;
  localparam int P_W           = 32;
  localparam int V_W           = FRAC_BITS + N_MAX + 3;
  localparam int SH_W          = $clog2(V_W);
  // lookup, multiply, one stage per exponent bit, output register
  localparam int NSTG          = FRAC_BITS + 3;
  localparam int TAB_N         = 1 << SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t blue_in;
    sample_t green_in;
    sample_t red_in;
  } in_pkt_t;

  typedef struct packed {
    sample_t blue_out;
    sample_t green_out;
    sample_t red_out;
  } out_pkt_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
  } flow_t;

  typedef logic [P_W-1:0] rtab_t [0:FRAC_BITS];
  typedef logic [L_W-1:0] ltab_t [0:TAB_N-1];

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x     = x_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x   = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // entry k holds 2^(-2^-k) in q1.31
  function automatic rtab_t build_roots();
    rtab_t t;
    logic [63:0] r;
    t[0] = P_W'(64'd1 << 30);
    for (int k = 1; k <= FRAC_BITS; k++) begin
      r    = isqrt64({32'd0, t[k-1]} << 31);
      t[k] = r[P_W-1:0];
    end
    return t;
  endfunction

  function automatic logic [63:0] log2_q30(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] frac;
    n    = '0;
    frac = '0;
    for (int i = 0; i < 40; i++) begin
      if ((x >> (n + 1)) != 0) n = n + 1;
    end
    m = x << (31 - n);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (n << FRAC_BITS) | frac;
  endfunction

  // log2(maxv) - log2(c); zero and full scale get entry zero, zero is handled outside the table
  function automatic ltab_t build_ltab();
    ltab_t t;
    logic [63:0] lm;
    logic [63:0] d;
    lm = log2_q30(64'(MAXV));
    for (int c = 0; c < TAB_N; c++) begin
      if (c == 0 || c >= MAXV) begin
        t[c] = '0;
      end else begin
        d    = lm - log2_q30(64'(c));
        t[c] = d[L_W-1:0];
      end
    end
    return t;
  endfunction

  localparam rtab_t ROOT_TAB = build_roots();
  localparam ltab_t LOG_TAB  = build_ltab();

endpackage

// File: src/rgb_gamma_correction.sv
// ----------------------------------------------------------------------------
// rgb_gamma_correction
// Per-channel gamma correction of one BGR pixel per request.
// ----------------------------------------------------------------------------
// Takes one pixel request every clock cycle while in_ready is high and offers
// each result through 33 register stages: a log table
// lookup, one gamma multiply, thirty conditional multiply stages of the exp2
// product chain and a rounding output register, with one lane of that
// pipeline per color channel. Stalls on the output side are absorbed by
// empty stages first, so input keeps flowing until the whole pipeline is
// full. No clearing pass after reset.
module rgb_gamma_correction import rgc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_pkt_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_pkt_t           out_data,
  input  logic               cfg_we,
  input  logic [GAMMA_W-1:0] cfg_wdata
);

  logic [GAMMA_W-1:0] gamma_r;
  logic [GAMMA_W-1:0] gamma_nxt;
  flow_t              flow;
  logic [NSTG-1:0]    vld;

  assign gamma_nxt = cfg_we ? cfg_wdata : gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_W'(1 << GAMMA_FRAC);
    end else begin
      gamma_r <= gamma_nxt;
    end
  end

  rgc_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flow      (flow),
    .vld       (vld)
  );

  rgc_lane u_lane_b (
    .clk     (clk),
    .flow    (flow),
    .gamma   (gamma_r),
    .smp_in  (in_data.blue_in),
    .smp_out (out_data.blue_out)
  );

  rgc_lane u_lane_g (
    .clk     (clk),
    .flow    (flow),
    .gamma   (gamma_r),
    .smp_in  (in_data.green_in),
    .smp_out (out_data.green_out)
  );

  rgc_lane u_lane_r (
    .clk     (clk),
    .flow    (flow),
    .gamma   (gamma_r),
    .smp_in  (in_data.red_in),
    .smp_out (out_data.red_out)
  );

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld))
    else $error("input stalled while pipeline has an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_zero_gamma: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && gamma_r == '0) |->
      (out_data.blue_out == SAMPLE_BITS'(MAXV) &&
       out_data.green_out == SAMPLE_BITS'(MAXV) &&
       out_data.red_out == SAMPLE_BITS'(MAXV)))
    else $error("zero gamma did not give full scale");
`endif

endmodule

// File: src/rgc_flow.sv
// ----------------------------------------------------------------------------
// rgc_flow
// Valid tracking and load enables for the shared lane pipeline.
// ----------------------------------------------------------------------------
module rgc_flow import rgc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output flow_t flow,
  output logic [NSTG-1:0] vld
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] room;
  logic [NSTG-1:0] take;
  logic [NSTG-1:0] load;

  // a stage has room when empty or when its request moves on this cycle
  always_comb begin
    take[NSTG-1] = out_ready;
    room[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      take[i] = room[i+1];
      room[i] = !v_r[i] || room[i+1];
    end
    load[0] = in_valid && room[0];
    for (int i = 1; i < NSTG; i++) begin
      load[i] = v_r[i-1] && room[i];
    end
    for (int i = 0; i < NSTG; i++) begin
      v_nxt[i] = load[i] || (v_r[i] && !take[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = room[0];
  assign out_valid = v_r[NSTG-1];
  assign flow.load = load;
  assign vld       = v_r;

endmodule

// File: src/rgc_lane.sv
// ----------------------------------------------------------------------------
// rgc_lane
// One color channel: log lookup, gamma multiply, exp2 product chain, rounding.
// ----------------------------------------------------------------------------
module rgc_lane import rgc_pkg::*; (
  input  logic               clk,
  input  flow_t              flow,
  input  logic [GAMMA_W-1:0] gamma,
  input  sample_t            smp_in,
  output sample_t            smp_out
);

  logic [L_W-1:0]       l0_r;
  logic                 zf0_r;
  logic [L_W+GAMMA_W-1:0] prod;
  logic [Y_W-1:0]       y;
  logic [Y_W-FRAC_BITS-1:0] n_full;

  logic                 zf_r [1:NSTG-2];
  logic [N_W-1:0]       n_r  [1:NSTG-2];
  logic [FRAC_BITS-1:0] f_r  [1:NSTG-2];
  logic [P_W-1:0]       p_r  [1:NSTG-2];

  logic [V_W-1:0]       v_w;
  logic [V_W-1:0]       vr;
  logic [V_W-1:0]       sh;
  sample_t              res;
  sample_t              out_r;

  always_ff @(posedge clk) begin
    if (flow.load[0]) begin
      l0_r  <= LOG_TAB[smp_in];
      zf0_r <= (smp_in == '0) && (gamma != '0);
    end
  end

  assign prod   = (L_W + GAMMA_W)'(l0_r) * (L_W + GAMMA_W)'(gamma);
  assign y      = prod[L_W+GAMMA_W-1:GAMMA_FRAC];
  assign n_full = y[Y_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (flow.load[1]) begin
      zf_r[1] <= zf0_r || (n_full > (Y_W - FRAC_BITS)'(N_MAX));
      n_r[1]  <= n_full[N_W-1:0];
      f_r[1]  <= y[FRAC_BITS-1:0];
      p_r[1]  <= P_W'(64'd1 << 31);
    end
  end

  // stage 1+k applies the factor 2^(-2^-k) when fraction bit k is set
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_exp
    logic [63:0] mul;
    assign mul = 64'(p_r[k]) * 64'(ROOT_TAB[k]);
    always_ff @(posedge clk) begin
      if (flow.load[k+1]) begin
        zf_r[k+1] <= zf_r[k];
        n_r[k+1]  <= n_r[k];
        f_r[k+1]  <= f_r[k];
        p_r[k+1]  <= f_r[k][FRAC_BITS-k] ? mul[62:31] : p_r[k];
      end
    end
  end

  always_comb begin
    v_w = V_W'(p_r[NSTG-2]) * V_W'(MAXV);
    vr  = v_w + (V_W'(1) << (SH_W'(FRAC_BITS) + SH_W'(n_r[NSTG-2])));
    sh  = vr >> (SH_W'(FRAC_BITS + 1) + SH_W'(n_r[NSTG-2]));
    if (zf_r[NSTG-2]) begin
      res = '0;
    end else if (sh > V_W'(MAXV)) begin
      res = SAMPLE_BITS'(MAXV);
    end else begin
      res = sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (flow.load[NSTG-1]) begin
      out_r <= res;
    end
  end

  assign smp_out = out_r;

endmodule

// File: tb/sv/rgb_gamma_correction_test.sv
// ----------------------------------------------------------------------------
// rgb_gamma_correction_test
// Self-checking bench: directed pixel table, then random pixels under several
// gamma settings, compared against a fixed-point gamma predictor.
// ----------------------------------------------------------------------------
module rgb_gamma_correction_test;
  import rgc_pkg::*;

  localparam int RANDOM_PIXELS = 900;
  localparam int DRAIN_CYCLES  = 80;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_pkt_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_pkt_t out_data;
  logic cfg_we = 1'b0;
  logic [GAMMA_W-1:0] cfg_wdata = '0;

  rgb_gamma_correction u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  out_pkt_t pending_pixels[$];
  int unsigned mismatch_cnt = 0;
  longint cycle_cnt = 0;
  bit hold_off = 1'b0;
  bit valid_on = 1'b0;
  logic [GAMMA_W-1:0] gamma_now = 16'd4096;
  logic [63:0] half_roots [0:FRAC_BITS];

  typedef struct {
    logic [GAMMA_W-1:0] gamma;
    in_pkt_t pix;
    bit known;
    out_pkt_t want;
  } stim_row_t;

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] x, r, b;
    x = val; r = 0; b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int unsigned e;
    logic [63:0] m, fr;
    e = 0; fr = 0;
    while (e < 40 && (x >> (e + 1)) != 0) e++;
    m = x << (31 - e);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        fr = fr | 64'd1;
      end
    end
    return (64'(e) << FRAC_BITS) | fr;
  endfunction

  function automatic sample_t gamma_sample(input sample_t c, input logic [GAMMA_W-1:0] g);
    logic [63:0] lm, lc, span, y, f, p, v, r;
    int unsigned e, s;
    if (g == 0) return sample_t'(MAXV);
    if (c == 0) return '0;
    if (c >= MAXV) return sample_t'(MAXV);
    lm = log2_fix(MAXV);
    lc = log2_fix(64'(c));
    span = (lc > lm) ? 64'd0 : lm - lc;
    y = (span * 64'(g)) >> GAMMA_FRAC;
    if ((y >> FRAC_BITS) > N_MAX) return '0;
    e = int'(y >> FRAC_BITS);
    f = y & ((64'd1 << FRAC_BITS) - 1);
    p = 64'd1 << 31;
    for (int k = 1; k <= FRAC_BITS; k++)
      if ((f >> (FRAC_BITS - k)) & 1) p = (p * half_roots[k]) >> 31;
    v = 64'(MAXV) * p;
    s = 31 + e;
    r = (v + (64'd1 << (s - 1))) >> s;
    return (r > MAXV) ? sample_t'(MAXV) : r[SAMPLE_BITS-1:0];
  endfunction

  function automatic out_pkt_t corrected_pixel(input in_pkt_t p, input logic [GAMMA_W-1:0] g);
    out_pkt_t o;
    o.blue_out  = gamma_sample(p.blue_in, g);
    o.green_out = gamma_sample(p.green_in, g);
    o.red_out   = gamma_sample(p.red_in, g);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("mismatch %s: got %0d want %0d (gamma %0d)", what, got, want, gamma_now);
  endtask

  // drop valid once the burst is over
  task automatic end_burst();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      end_burst();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pixel(input in_pkt_t p, input bit known, input out_pkt_t want);
    out_pkt_t calc;
    calc = corrected_pixel(p, gamma_now);
    if (known && calc != want) report_mismatch("table entry vs predictor", calc, want);
    pending_pixels.push_back(known ? want : calc);
    in_valid <= 1'b1;
    valid_on = 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_gamma(input logic [GAMMA_W-1:0] g);
    end_burst();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gamma_now = g;
  endtask

  task automatic random_pixel(output in_pkt_t p);
    int mode;
    mode = $urandom_range(0, 9);
    p = in_pkt_t'($urandom);
    if (mode == 0) p.blue_in = '0;
    if (mode == 1) p.red_in = sample_t'(MAXV);
    if (mode == 2) p.green_in = sample_t'($urandom_range(1, 3));
  endtask

  always @(posedge clk) begin
    out_pkt_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[rgb_gamma_correction] ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_data, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.blue_out != want.blue_out)
          report_mismatch("blue_out", out_data.blue_out, want.blue_out);
        if (out_data.green_out != want.green_out)
          report_mismatch("green_out", out_data.green_out, want.green_out);
        if (out_data.red_out != want.red_out)
          report_mismatch("red_out", out_data.red_out, want.red_out);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        n = $urandom_range(0, 3);
        out_ready <= (n != 0);
        @(posedge clk);
        if (n == 0 && $urandom_range(0, 15) == 0) repeat ($urandom_range(5, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [GAMMA_W-1:0] gammas[] = '{16'd0, 16'd65535, 16'd1, 16'd2048, 16'd9011, 16'd4096};
    in_pkt_t p;
    out_pkt_t none;
    half_roots[0] = 64'd1 << 30;
    for (int k = 1; k <= FRAC_BITS; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 31);
    none = '0;
    // gamma at reset is 1.0: identity
    rows.push_back('{16'd4096, '{8'd0, 8'd255, 8'd1}, 1'b1, '{8'd0, 8'd255, 8'd1}});
    rows.push_back('{16'd4096, '{8'd128, 8'd200, 8'd17}, 1'b1, '{8'd128, 8'd200, 8'd17}});
    rows.push_back('{16'd4096, '{8'd170, 8'd85, 8'd254}, 1'b0, none});
    // zero gamma gives full scale everywhere
    rows.push_back('{16'd0, '{8'd0, 8'd255, 8'd1}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{16'd0, '{8'd85, 8'd170, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    // largest gamma: tiny results drop to zero, full scale stays
    rows.push_back('{16'd65535, '{8'd0, 8'd255, 8'd1}, 1'b1, '{8'd0, 8'd255, 8'd0}});
    rows.push_back('{16'd65535, '{8'd254, 8'd250, 8'd240}, 1'b0, none});
    rows.push_back('{16'd1, '{8'd1, 8'd2, 8'd254}, 1'b0, none});
    rows.push_back('{16'd1, '{8'd0, 8'd128, 8'd255}, 1'b0, none});
    rows.push_back('{16'd2048, '{8'd1, 8'd64, 8'd192}, 1'b0, none});
    rows.push_back('{16'd9011, '{8'd1, 8'd100, 8'd254}, 1'b0, none});
    rows.push_back('{16'd32768, '{8'd1, 8'd200, 8'd254}, 1'b0, none});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].gamma != gamma_now) write_gamma(rows[i].gamma);
      send_pixel(rows[i].pix, rows[i].known, rows[i].want);
      idle_gap();
    end

    foreach (gammas[gi]) begin
      write_gamma(($urandom_range(0, 1) == 0) ? gammas[gi] : 16'($urandom));
      write_gamma(gammas[gi]);
      for (int i = 0; i < RANDOM_PIXELS / 6; i++) begin
        if (gi == 2 && i == 10) hold_off = 1'b1;
        random_pixel(p);
        send_pixel(p, 1'b0, none);
        // back-to-back bursts keep valid high between requests
        if ((gi == 2 && i < 80) || $urandom_range(0, 3) != 0) continue;
        idle_gap();
      end
      end_burst();
    end

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[rgb_gamma_correction] OK");
    end else begin
      $display("[rgb_gamma_correction] ERROR");
    end
    $finish;
  end

endmodule
